// File: src/pressure_regulator_supervisor_unit_macros.svh
// ---------------------------------------------------------------------------
// Pressure regulator supervisor assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef PRESSURE_REGULATOR_SUPERVISOR_UNIT_MACROS_SVH
`define PRESSURE_REGULATOR_SUPERVISOR_UNIT_MACROS_SVH

// Same-cycle implication
`define PRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prs check failed");

// Next-cycle implication
`define PRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prs check failed");

`endif

// File: src/prs_pkg.sv
// ---------------------------------------------------------------------------
// Pressure regulator supervisor package
// Types, register indexes, reset values and fault codes shared by the unit.
// ---------------------------------------------------------------------------
package prs_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESSURE_OFFSET = 3'd0,
        REG_HYST_WIDTH      = 3'd1,
        REG_DAC_GAIN        = 3'd2,
        REG_BAND_CROSSOVER  = 3'd3,
        REG_BAND_LOW        = 3'd4,
        REG_BAND_HIGH       = 3'd5,
        REG_TRIP_TIME_MS    = 3'd6,
        REG_PROTECT_ENABLE  = 3'd7
    } cfg_idx_t;

    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [15:0] RST_PRESSURE_OFFSET = 16'd0;
    localparam logic [15:0] RST_HYSTERESIS      = 16'd128;
    localparam logic [15:0] RST_DAC_GAIN        = 16'd10496;
    localparam logic [15:0] RST_BAND_CROSSOVER  = 16'd5120;
    localparam logic [15:0] RST_BAND_LOW        = 16'd256;
    localparam logic [15:0] RST_BAND_HIGH       = 16'd512;
    localparam logic [31:0] RST_TRIP_TIME_MS    = 32'd5000;
    localparam logic        RST_PROTECT_ENABLE  = 1'b1;

    // Input function codes
    localparam logic FUNC_SET_TARGET = 1'b0;
    localparam logic FUNC_UPDATE     = 1'b1;

    // Fault codes
    typedef enum logic [1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_REMOVED = 2'd1,
        FAULT_RUNAWAY = 2'd2,
        FAULT_LEAK    = 2'd3
    } fault_t;

    localparam logic [11:0] DAC_MAX = 12'hFFF;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [15:0] pressure_offset;
        logic [15:0] hysteresis;
        logic [15:0] dac_gain;
        logic [15:0] band_crossover;
        logic [15:0] band_low;
        logic [15:0] band_high;
        logic [31:0] trip_time_ms;
        logic        protect_enable;
    } cfg_t;

    typedef struct packed {
        logic        func;
        logic [15:0] setpoint;
        logic [15:0] regulator_pressure;
        logic [15:0] supply_pressure;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic        dac_strobe;
        logic [11:0] dac_code;
        fault_t      fault_code;
        logic        is_active;
        logic        last_result;
    } result_t;

    // Results produced by one transaction, first before second
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// File: src/prs_config_regs.sv
// ---------------------------------------------------------------------------
// Pressure regulator supervisor configuration registers
// Write-only register file decoded from the plain write port.
// ---------------------------------------------------------------------------
module prs_config_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [prs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prs_pkg::CFG_DATA_W-1:0] cfg_data,
    output prs_pkg::cfg_t                  cfg
);
    import prs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PRESSURE_OFFSET: cfg_next.pressure_offset = cfg_data[15:0];
                REG_HYST_WIDTH:      cfg_next.hysteresis      = cfg_data[15:0];
                REG_DAC_GAIN:        cfg_next.dac_gain        = cfg_data[15:0];
                REG_BAND_CROSSOVER:  cfg_next.band_crossover  = cfg_data[15:0];
                REG_BAND_LOW:        cfg_next.band_low        = cfg_data[15:0];
                REG_BAND_HIGH:       cfg_next.band_high       = cfg_data[15:0];
                REG_TRIP_TIME_MS:    cfg_next.trip_time_ms    = cfg_data[31:0];
                REG_PROTECT_ENABLE:  cfg_next.protect_enable  = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pressure_offset        <= RST_PRESSURE_OFFSET;
            cfg_reg.hysteresis             <= RST_HYSTERESIS;
            cfg_reg.dac_gain               <= RST_DAC_GAIN;
            cfg_reg.band_crossover         <= RST_BAND_CROSSOVER;
            cfg_reg.band_low               <= RST_BAND_LOW;
            cfg_reg.band_high              <= RST_BAND_HIGH;
            cfg_reg.trip_time_ms           <= RST_TRIP_TIME_MS;
            cfg_reg.protect_enable         <= RST_PROTECT_ENABLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/prs_core.sv
// ---------------------------------------------------------------------------
// Pressure regulator supervisor core
// Regulator state and the single-pass datapath: DAC code for a new target,
// supply and band protection for an update.
// ---------------------------------------------------------------------------
module prs_core #(
    parameter logic [15:0] SUPPLY_MIN_PRESSURE = 16'd1280,
    parameter logic [15:0] ABSENT_PRESSURE     = 16'd30720
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  prs_pkg::item_t item,
    input  prs_pkg::cfg_t  cfg,
    output prs_pkg::push_t push
);
    import prs_pkg::*;

    logic [15:0] target_reg;
    logic [15:0] target_next;
    logic        active_reg;
    logic        active_next;
    logic [31:0] timer_start_reg;
    logic [31:0] timer_start_next;
    logic        timer_valid_reg;
    logic        timer_valid_next;

    logic [16:0] off_hys;
    logic [16:0] diff;
    logic [32:0] product;
    logic [16:0] quotient;
    logic [11:0] dac_code;

    logic        prot_run;
    logic [31:0] start_eff;
    logic [31:0] elapsed;
    logic        trip;
    logic [15:0] band;
    logic        under;
    logic        over;
    logic        supply_fault;
    logic        band_fault;
    fault_t      band_code;
    result_t     res_set;
    result_t     res_supply;
    result_t     res_band;

    // DAC code for a new target
    always_comb
    begin
        off_hys = {1'b0, cfg.pressure_offset} + {1'b0, cfg.hysteresis};
        if ({1'b0, item.setpoint} <= off_hys)
        begin
            diff = '0;
        end
        else if (item.setpoint > item.regulator_pressure)
        begin
            diff = {1'b0, item.setpoint} - {1'b0, cfg.pressure_offset}
                 + {1'b0, cfg.hysteresis};
        end
        else if (item.setpoint < item.regulator_pressure)
        begin
            diff = {1'b0, item.setpoint} - off_hys;
        end
        else
        begin
            diff = '0;
        end
        product  = diff * {17'd0, cfg.dac_gain};
        quotient = product[32:16];
        dac_code = (|quotient[16:12]) ? DAC_MAX : quotient[11:0];
    end

    // Protection checks against the held target
    always_comb
    begin
        prot_run     = (item.func == FUNC_UPDATE) && cfg.protect_enable;
        start_eff    = timer_valid_reg ? timer_start_reg : item.now_ms;
        elapsed      = item.now_ms - start_eff;
        trip         = elapsed > cfg.trip_time_ms;
        band         = (target_reg <= cfg.band_crossover) ? cfg.band_low : cfg.band_high;
        under        = ({1'b0, item.regulator_pressure} + {1'b0, band})
                       <= {1'b0, target_reg};
        over         = {1'b0, item.regulator_pressure}
                       >= ({1'b0, target_reg} + {1'b0, band});
        supply_fault = active_reg && prot_run
                       && (item.regulator_pressure >= item.supply_pressure)
                       && (item.supply_pressure >= SUPPLY_MIN_PRESSURE)
                       && (item.regulator_pressure >= ABSENT_PRESSURE);
        band_fault   = active_reg && prot_run && (over || under) && trip;
        if (item.regulator_pressure >= ABSENT_PRESSURE)
        begin
            band_code = FAULT_REMOVED;
        end
        else if (over)
        begin
            band_code = FAULT_RUNAWAY;
        end
        else
        begin
            band_code = FAULT_LEAK;
        end
    end

    // Build the results and the next state
    always_comb
    begin
        res_set    = '{dac_strobe: 1'b1, dac_code: dac_code, fault_code: FAULT_NONE,
                       is_active: 1'b1, last_result: 1'b1};
        res_supply = '{dac_strobe: 1'b1, dac_code: '0, fault_code: FAULT_REMOVED,
                       is_active: 1'b0, last_result: !band_fault};
        res_band   = '{dac_strobe: 1'b1, dac_code: '0, fault_code: band_code,
                       is_active: 1'b0, last_result: 1'b1};

        target_next      = target_reg;
        active_next      = active_reg;
        timer_start_next = timer_start_reg;
        timer_valid_next = timer_valid_reg;
        push.count       = 2'd0;
        push.first       = res_set;
        push.second      = res_band;

        if (item.func == FUNC_SET_TARGET)
        begin
            target_next = item.setpoint;
            active_next = 1'b1;
            push.count  = 2'd1;
        end
        else if (prot_run)
        begin
            timer_valid_next = 1'b1;
            if (!active_reg || !(over || under) || trip)
            begin
                timer_start_next = item.now_ms;
            end
            else
            begin
                timer_start_next = start_eff;
            end
            if (supply_fault || band_fault)
            begin
                target_next = '0;
                active_next = 1'b0;
            end
            if (supply_fault)
            begin
                push.first = res_supply;
                push.count = band_fault ? 2'd2 : 2'd1;
            end
            else if (band_fault)
            begin
                push.first = res_band;
                push.count = 2'd1;
            end
        end
    end

    // Commit state as the transaction leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg      <= '0;
            active_reg      <= 1'b0;
            timer_start_reg <= '0;
            timer_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            target_reg      <= target_next;
            active_reg      <= active_next;
            timer_start_reg <= timer_start_next;
            timer_valid_reg <= timer_valid_next;
        end
    end

endmodule

// File: src/prs_result_fifo.sv
// ---------------------------------------------------------------------------
// Pressure regulator supervisor result queue
// Small register queue that takes up to two results a cycle and hands out one.
// ---------------------------------------------------------------------------
module prs_result_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_en,
    input  prs_pkg::push_t   push,
    input  logic             pop,
    output logic             not_empty,
    output logic             room,
    output prs_pkg::result_t head
);
    import prs_pkg::*;

    result_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;
    logic [FIFO_CNT_W-1:0]   push_n;
    logic [FIFO_PTR_W-1:0]   wr_ptr_plus1;

    // Advance pointers and fill level
    always_comb
    begin
        push_n       = push_en ? FIFO_CNT_W'(push.count) : '0;
        wr_ptr_plus1 = wr_ptr_reg + 1'b1;
        wr_ptr_next  = wr_ptr_reg + push_n[FIFO_PTR_W-1:0];
        rd_ptr_next  = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next   = count_reg + push_n - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the results of one transaction
    always_ff @(posedge clk)
    begin
        if (push_n != '0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push_n == FIFO_CNT_W'(2))
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

    assign not_empty = (count_reg != '0);
    assign room      = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign head      = entry_reg[rd_ptr_reg];

endmodule

// File: src/pressure_regulator_supervisor_unit.sv
// ---------------------------------------------------------------------------
// Pressure regulator supervisor unit
// Sets the regulator target and DAC code, and supervises supply and band
// faults on periodic updates.
// ---------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | in_valid, in_stall | func, setpoint, regulator_pressure,
//           |                    | supply_pressure, now_ms
//  result   | out_valid,         | dac_strobe, dac_code, fault_code, is_active,
//           | out_stall          | last_result
//  config   | cfg_we             | cfg_index, cfg_data
//
//  One transaction a cycle while in_stall is low: an accepted item waits
//  in the input register, is worked in a single pass and its results are
//  queued. The first result is offered once the item has left the input
//  register and been written into the result queue; an update with two
//  faults queues two results, handed out one a cycle while out_stall is low.
//  Input stalls only while an item waits and the result queue holds more
//  than two entries.
//  Reset clears the regulator state, queue and registers to their defaults.
// ---------------------------------------------------------------------------
module pressure_regulator_supervisor_unit #(
    parameter logic [15:0] SUPPLY_MIN_PRESSURE = 16'd1280,
    parameter logic [15:0] ABSENT_PRESSURE     = 16'd30720
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [prs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [15:0]                    setpoint,
    input  logic [15:0]                    regulator_pressure,
    input  logic [15:0]                    supply_pressure,
    input  logic [31:0]                    now_ms,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           dac_strobe,
    output logic [11:0]                    dac_code,
    output logic [1:0]                     fault_code,
    output logic                           is_active,
    output logic                           last_result
);
    import prs_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    logic    advance;
    logic    room;
    logic    pop;
    push_t   push;
    result_t head;

    prs_config_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input stage handshake
    assign advance       = s1_valid_reg && room;
    assign in_stall      = s1_valid_reg && !room;
    assign s1_valid_next = in_stall ? s1_valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= '{func: func, setpoint: setpoint,
                          regulator_pressure: regulator_pressure,
                          supply_pressure: supply_pressure, now_ms: now_ms};
        end
    end

    prs_core #(
        .SUPPLY_MIN_PRESSURE (SUPPLY_MIN_PRESSURE),
        .ABSENT_PRESSURE     (ABSENT_PRESSURE)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .push    (push)
    );

    // Result queue and output port
    assign pop = out_valid && !out_stall;

    prs_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (advance),
        .push      (push),
        .pop       (pop),
        .not_empty (out_valid),
        .room      (room),
        .head      (head)
    );

    assign dac_strobe  = head.dac_strobe;
    assign dac_code    = head.dac_code;
    assign fault_code  = head.fault_code;
    assign is_active   = head.is_active;
    assign last_result = head.last_result;

endmodule

// File: src/prs_checker.sv
// ---------------------------------------------------------------------------
// Pressure regulator supervisor port checker
// Watches the result channel for results that break the unit's rules.
// ---------------------------------------------------------------------------
`include "pressure_regulator_supervisor_unit_macros.svh"

module prs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        dac_strobe,
    input logic [11:0] dac_code,
    input logic [1:0]  fault_code,
    input logic        is_active,
    input logic        last_result
);
    import prs_pkg::*;

    logic is_fault;

    // Flag a fault result
    assign is_fault = (fault_code != FAULT_NONE);

    // Hold a stalled result
    `PRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // Target results are final, active and written
    `PRS_ASSERT_NOW(a_set_result, out_valid && !is_fault, dac_strobe && is_active && last_result)

    // Fault results zero the DAC and deactivate
    `PRS_ASSERT_NOW(a_fault_result, out_valid && is_fault, dac_strobe && !is_active && dac_code == '0)

    // Only the supply fault can be followed by a second result
    `PRS_ASSERT_NOW(a_first_of_two, out_valid && !last_result, fault_code == FAULT_REMOVED)

endmodule

bind pressure_regulator_supervisor_unit prs_checker u_prs_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pressure regulator supervisor testbench
// Drives set-target and protection-update transactions through the
// valid/stall input channel, predicts the DAC and fault results in a mirror
// of the supervisor state, and compares every result field by field. The
// run steps through several register settings, extremes included, with
// random idling on both channels.
// ---------------------------------------------------------------------------
module tb_top;
    import prs_pkg::*;

    localparam logic [15:0] SUPPLY_FLOOR      = 16'd1280;
    localparam logic [15:0] ABSENT_LEVEL      = 16'd30720;
    localparam int          NUM_SETTINGS      = 6;
    localparam int          ITEMS_PER_SETTING = 250;
    localparam int          DRAIN_CYCLES      = 6;

    // -----------------------------------------------------------------------
    // Mirror of the supervisor: registers, regulator state, pending results
    // -----------------------------------------------------------------------
    class supervisor_mirror;
        logic [15:0] offset, hyst, gain, crossover, band_lo, band_hi;
        logic [31:0] trip;
        logic        protect;
        logic [15:0] target;
        logic        active;
        logic [31:0] timer_start;
        logic        timer_loaded;
        result_t     pending_results[$];
        int          mismatches;
        int          items_taken;
        int          results_matched;
        int          faults_seen[4];

        function new();
            offset       = RST_PRESSURE_OFFSET;
            hyst         = RST_HYSTERESIS;
            gain         = RST_DAC_GAIN;
            crossover    = RST_BAND_CROSSOVER;
            band_lo      = RST_BAND_LOW;
            band_hi      = RST_BAND_HIGH;
            trip         = RST_TRIP_TIME_MS;
            protect      = RST_PROTECT_ENABLE;
            target       = '0;
            active       = 1'b0;
            timer_start  = '0;
            timer_loaded = 1'b0;
            mismatches   = 0;
            items_taken  = 0;
            results_matched = 0;
            foreach (faults_seen[i]) faults_seen[i] = 0;
        endfunction

        // Print one line and count
        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        function void set_reg(cfg_idx_t idx, logic [31:0] data);
            case (idx)
                REG_PRESSURE_OFFSET: offset    = data[15:0];
                REG_HYST_WIDTH:      hyst      = data[15:0];
                REG_DAC_GAIN:        gain      = data[15:0];
                REG_BAND_CROSSOVER:  crossover = data[15:0];
                REG_BAND_LOW:        band_lo   = data[15:0];
                REG_BAND_HIGH:       band_hi   = data[15:0];
                REG_TRIP_TIME_MS:    trip      = data;
                REG_PROTECT_ENABLE:  protect   = data[0];
                default: ;
            endcase
        endfunction

        // Gain times the hysteresis-adjusted error, Q16.16 truncated, saturated
        function logic [11:0] dac_code_for(logic [15:0] want, logic [15:0] meas);
            longint err;
            longint prod;
            longint codes;
            err = 0;
            if (longint'(want) <= longint'(offset) + longint'(hyst))
                err = 0;
            else if (want > meas)
                err = longint'(want) - longint'(offset) + longint'(hyst);
            else if (want < meas)
                err = longint'(want) - longint'(offset) - longint'(hyst);
            prod = err * longint'(gain);
            if (prod <= 0)
                return 12'd0;
            codes = prod / 65536;
            return (codes > 4095) ? DAC_MAX : codes[11:0];
        endfunction

        function result_t trip_fault(fault_t code);
            result_t r;
            target        = '0;
            active        = 1'b0;
            r.dac_strobe  = 1'b1;
            r.dac_code    = 12'd0;
            r.fault_code  = code;
            r.is_active   = 1'b0;
            r.last_result = 1'b0;
            return r;
        endfunction

        // Advance the state for one accepted transaction and queue its results
        function void take_item(item_t it);
            result_t     outs[$];
            result_t     r;
            int          tgt;
            int          band;
            int          regp;
            logic        under;
            logic        over;
            logic [31:0] elapsed;
            fault_t      code;
            items_taken++;
            if (it.func == FUNC_SET_TARGET)
            begin
                active        = 1'b1;
                target        = it.setpoint;
                r.dac_strobe  = 1'b1;
                r.dac_code    = dac_code_for(it.setpoint, it.regulator_pressure);
                r.fault_code  = FAULT_NONE;
                r.is_active   = 1'b1;
                r.last_result = 1'b1;
                pending_results.push_back(r);
                return;
            end
            if (!protect)
                return;
            if (!timer_loaded)
            begin
                timer_start  = it.now_ms;
                timer_loaded = 1'b1;
            end
            if (!active)
            begin
                timer_start = it.now_ms;
                return;
            end
            // Band check uses the target held before any supply fault
            tgt  = target;
            regp = it.regulator_pressure;
            if (it.regulator_pressure >= it.supply_pressure &&
                it.supply_pressure >= SUPPLY_FLOOR &&
                it.regulator_pressure >= ABSENT_LEVEL)
                outs.push_back(trip_fault(FAULT_REMOVED));
            band  = (tgt <= int'(crossover)) ? int'(band_lo) : int'(band_hi);
            under = regp <= tgt - band;
            over  = regp >= tgt + band;
            if (under || over)
            begin
                elapsed = it.now_ms - timer_start;
                if (elapsed > trip)
                begin
                    if (it.regulator_pressure >= ABSENT_LEVEL)
                        code = FAULT_REMOVED;
                    else if (over)
                        code = FAULT_RUNAWAY;
                    else
                        code = FAULT_LEAK;
                    outs.push_back(trip_fault(code));
                    timer_start = it.now_ms;
                end
            end
            else
            begin
                timer_start = it.now_ms;
            end
            if (outs.size() > 0)
                outs[outs.size()-1].last_result = 1'b1;
            foreach (outs[i]) pending_results.push_back(outs[i]);
        endfunction

        // Compare one accepted result with the oldest expectation
        task match_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                report("result arrived with nothing expected");
                return;
            end
            want = pending_results.pop_front();
            results_matched++;
            faults_seen[want.fault_code]++;
            if (got.dac_strobe !== want.dac_strobe)
                report($sformatf("dac_strobe %b, expected %b",
                                 got.dac_strobe, want.dac_strobe));
            if (got.dac_code !== want.dac_code)
                report($sformatf("dac_code %0d, expected %0d", got.dac_code, want.dac_code));
            if (got.fault_code !== want.fault_code)
                report($sformatf("fault_code %0d, expected %0d",
                                 got.fault_code, want.fault_code));
            if (got.is_active !== want.is_active)
                report($sformatf("is_active %b, expected %b", got.is_active, want.is_active));
            if (got.last_result !== want.last_result)
                report($sformatf("last_result %b, expected %b",
                                 got.last_result, want.last_result));
        endtask
    endclass

    // -----------------------------------------------------------------------
    // Signals and instance
    // -----------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  func;
    logic [15:0]           setpoint;
    logic [15:0]           regulator_pressure;
    logic [15:0]           supply_pressure;
    logic [31:0]           now_ms;
    logic                  out_valid;
    logic                  out_stall;
    logic                  dac_strobe;
    logic [11:0]           dac_code;
    logic [1:0]            fault_code;
    logic                  is_active;
    logic                  last_result;

    supervisor_mirror mirror;
    logic             calm;
    logic [31:0]      clock_ms;

    pressure_regulator_supervisor_unit dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .func               (func),
        .setpoint           (setpoint),
        .regulator_pressure (regulator_pressure),
        .supply_pressure    (supply_pressure),
        .now_ms             (now_ms),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .dac_strobe         (dac_strobe),
        .dac_code           (dac_code),
        .fault_code         (fault_code),
        .is_active          (is_active),
        .last_result        (last_result)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Stall the result channel at random, except during the calm stretch
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = !calm && ($urandom_range(0, 99) < 24);
        end
    end

    // Check every accepted result transaction
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.dac_strobe  = dac_strobe;
            got.dac_code    = dac_code;
            got.fault_code  = fault_t'(fault_code);
            got.is_active   = is_active;
            got.last_result = last_result;
            mirror.match_result(got);
        end
    end

    // -----------------------------------------------------------------------
    // Drive helpers: each starts and ends at a falling edge
    // -----------------------------------------------------------------------
    task automatic send(item_t it);
        while (!calm && $urandom_range(0, 99) < 24)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid           = 1'b1;
        func               = it.func;
        setpoint           = it.setpoint;
        regulator_pressure = it.regulator_pressure;
        supply_pressure    = it.supply_pressure;
        now_ms             = it.now_ms;
        // Hold until the transaction is taken
        do
            @(posedge clk);
        while (in_stall);
        mirror.take_item(it);
        @(negedge clk);
    endtask

    task automatic send_fields(logic f, logic [15:0] d, logic [15:0] r, logic [15:0] s,
                               logic [31:0] t);
        item_t it;
        it.func               = f;
        it.setpoint           = d;
        it.regulator_pressure = r;
        it.supply_pressure    = s;
        it.now_ms             = t;
        send(it);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        mirror.set_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Pause the sender until every expected result has come back
    task automatic wait_drain();
        in_valid = 1'b0;
        while (mirror.pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Load one register setting while the block is idle
    task automatic apply_setting(int sel);
        logic [31:0] vals[8];
        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        case (sel)
            1:
            begin
                // Zero bands, zero trip time, full gain
                vals = '{32'd0, 32'd0, 32'h0000_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1};
            end
            2:
            begin
                // Everything but the gain at its top; upper bits of narrow registers set
                vals = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            end
            3:
            begin
                // Protection off, zero gain
                vals = '{$urandom_range(0, 4000), $urandom_range(0, 1000), 32'd0,
                         $urandom_range(0, 65535), $urandom_range(0, 3000),
                         $urandom_range(0, 3000), $urandom_range(0, 6000), 32'hFFFF_FFFE};
            end
            4:
            begin
                // Moderate random values with junk in the unused upper bits
                vals = '{{16'($urandom), 16'($urandom_range(0, 3000))},
                         {16'($urandom), 16'($urandom_range(0, 600))},
                         $urandom,
                         {16'($urandom), 16'($urandom)},
                         {16'($urandom), 16'($urandom_range(0, 3000))},
                         {16'($urandom), 16'($urandom_range(0, 3000))},
                         $urandom_range(0, 3000),
                         {31'($urandom), 1'b1}};
            end
            default:
            begin
                vals = '{32'(RST_PRESSURE_OFFSET), 32'(RST_HYSTERESIS), 32'(RST_DAC_GAIN),
                         32'(RST_BAND_CROSSOVER), 32'(RST_BAND_LOW), 32'(RST_BAND_HIGH),
                         RST_TRIP_TIME_MS, 32'(RST_PROTECT_ENABLE)};
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(cfg_idx_t'(i), vals[i]);
    endtask

    // -----------------------------------------------------------------------
    // Random stimulus
    // -----------------------------------------------------------------------
    function automatic logic [15:0] clamp16(int v);
        if (v < 0)
            return 16'd0;
        if (v > 65535)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    function automatic int jitter(int n);
        return int'($urandom_range(0, 2 * n)) - n;
    endfunction

    // Build the next transaction of an episode: a set-target opens it,
    // updates follow round the band edges and the trip time
    function automatic item_t next_item(bit opening);
        item_t it;
        int    tgt;
        int    band;
        it.func               = 1'($urandom);
        it.setpoint           = 16'($urandom);
        it.regulator_pressure = 16'($urandom);
        it.supply_pressure    = 16'($urandom);
        it.now_ms             = $urandom;
        // Plain noise now and then
        if ($urandom_range(0, 99) < 10)
            return it;
        tgt  = mirror.target;
        band = (tgt <= int'(mirror.crossover)) ? int'(mirror.band_lo) : int'(mirror.band_hi);
        if (opening)
        begin
            it.func = FUNC_SET_TARGET;
            case ($urandom_range(0, 4))
                0: ;
                1: it.setpoint = 16'($urandom_range(0, 1023));
                2: it.setpoint = clamp16(int'(mirror.crossover) + jitter(2));
                3: it.setpoint = clamp16(int'(mirror.offset) + int'(mirror.hyst)
                                         + jitter(2));
                default: it.setpoint = 16'($urandom_range(30000, 65535));
            endcase
            case ($urandom_range(0, 3))
                0: it.regulator_pressure = it.setpoint;
                1: it.regulator_pressure = clamp16(int'(it.setpoint) + 1);
                2: it.regulator_pressure = clamp16(int'(it.setpoint) - 1);
                default: ;
            endcase
            return it;
        end
        it.func = FUNC_UPDATE;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: clock_ms = clock_ms + $urandom_range(0, 300);
            4, 5, 6:    clock_ms = mirror.timer_start + mirror.trip + 32'(jitter(1));
            7, 8:       clock_ms = clock_ms + $urandom_range(0, 20000);
            default:    clock_ms = $urandom;
        endcase
        it.now_ms = clock_ms;
        case ($urandom_range(0, 7))
            0: it.regulator_pressure = clamp16(tgt - band);
            1: it.regulator_pressure = clamp16(tgt - band + 1);
            2: it.regulator_pressure = clamp16(tgt + band);
            3: it.regulator_pressure = clamp16(tgt + band - 1);
            4: it.regulator_pressure = clamp16(tgt + jitter(8));
            5: it.regulator_pressure = ABSENT_LEVEL + 16'($urandom_range(0, 65535 - 30720));
            default: ;
        endcase
        case ($urandom_range(0, 6))
            0: it.supply_pressure = it.regulator_pressure;
            1: it.supply_pressure = clamp16(int'(it.regulator_pressure) - 1);
            2: it.supply_pressure = clamp16(int'(it.regulator_pressure) + 1);
            3: it.supply_pressure = SUPPLY_FLOOR;
            4: it.supply_pressure = SUPPLY_FLOOR - 16'd1;
            5: it.supply_pressure = 16'hFFFF;
            default: ;
        endcase
        return it;
    endfunction

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        int left;
        int guard;
        mirror             = new();
        calm               = 1'b0;
        clock_ms           = '0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        in_valid           = 1'b0;
        func               = FUNC_SET_TARGET;
        setpoint           = '0;
        regulator_pressure = '0;
        supply_pressure    = '0;
        now_ms             = '0;
        left               = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under the reset settings
        send_fields(FUNC_UPDATE, 16'd0, 16'd0, 16'd0, 32'd100);          // inactive update
        send_fields(FUNC_SET_TARGET, 16'd0, 16'd0, 16'd0, 32'd0);        // zero target
        send_fields(FUNC_SET_TARGET, 16'd128, 16'd0, 16'd0, 32'd0);      // at offset + hyst
        send_fields(FUNC_SET_TARGET, 16'd129, 16'd0, 16'd0, 32'd0);      // just above, rising
        send_fields(FUNC_SET_TARGET, 16'd1000, 16'd1000, 16'd0, 32'd0);  // equal to measured
        send_fields(FUNC_SET_TARGET, 16'd1000, 16'd2000, 16'd0, 32'd0);  // falling
        send_fields(FUNC_SET_TARGET, 16'hFFFF, 16'd0, 16'hFFFF, 32'hFFFF_FFFF); // saturation
        send_fields(FUNC_SET_TARGET, 16'hFFFF, 16'hFFFF, 16'd0, 32'd0);  // equal at the top
        send_fields(FUNC_SET_TARGET, 16'd2560, 16'd0, 16'd0, 32'd0);
        send_fields(FUNC_UPDATE, 16'd0, 16'd2560, 16'hFFFF, 32'd200);    // in band
        send_fields(FUNC_UPDATE, 16'd0, 16'd2304, 16'hFFFF, 32'd5200);   // under, at trip time
        send_fields(FUNC_UPDATE, 16'd0, 16'd2304, 16'hFFFF, 32'd5201);   // leak
        send_fields(FUNC_SET_TARGET, 16'd2560, 16'd0, 16'd0, 32'd0);
        send_fields(FUNC_UPDATE, 16'd0, 16'd2816, 16'hFFFF, 32'd10202);  // runaway
        send_fields(FUNC_SET_TARGET, 16'd40000, 16'd0, 16'd0, 32'd0);
        send_fields(FUNC_UPDATE, 16'd0, 16'd40000, 16'd40000, 32'd10300); // supply exceeded
        send_fields(FUNC_SET_TARGET, 16'd2560, 16'd0, 16'd0, 32'd0);
        send_fields(FUNC_UPDATE, 16'd0, 16'hFFFF, 16'd2000, 32'd20000);  // two faults at once
        send_fields(FUNC_SET_TARGET, 16'd2560, 16'd0, 16'd0, 32'd0);
        send_fields(FUNC_UPDATE, 16'd0, 16'd40000, 16'd0, 32'd30000);    // removed via band
        send_fields(FUNC_SET_TARGET, 16'd5120, 16'd0, 16'd0, 32'd0);     // at the crossover
        send_fields(FUNC_UPDATE, 16'd0, 16'd5120, 16'd1279, 32'hFFFF_FF00);
        send_fields(FUNC_UPDATE, 16'd0, 16'd5376, 16'd1280, 32'h0000_1300); // timer wraps
        send_fields(FUNC_UPDATE, 16'd0, 16'd0, 16'd0, 32'h0000_1400);    // inactive again

        // Random episodes under each register setting
        for (int sel = 0; sel < NUM_SETTINGS; sel++)
        begin
            if (sel > 0)
                apply_setting(sel);
            clock_ms = (sel % 2) ? 32'hFFFF_F000 : $urandom_range(0, 1000);
            for (int i = 0; i < ITEMS_PER_SETTING; i++)
            begin
                calm = (sel == NUM_SETTINGS - 1) && (i < 200);
                if (i == ITEMS_PER_SETTING / 2)
                    wait_drain();
                send(next_item(left == 0));
                if (left == 0)
                    left = $urandom_range(2, 10);
                else
                    left--;
            end
        end
        calm     = 1'b0;
        in_valid = 1'b0;

        // Drain, then let the pipeline settle
        guard = 0;
        while (mirror.pending_results.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (20) @(negedge clk);
        if (mirror.pending_results.size() != 0)
            mirror.report($sformatf("%0d expected results never arrived",
                                    mirror.pending_results.size()));

        $display("Summary: %0d transactions over %0d register settings, %0d results compared",
                 mirror.items_taken, NUM_SETTINGS, mirror.results_matched);
        $display("Summary: faults removed %0d, runaway %0d, leak %0d",
                 mirror.faults_seen[FAULT_REMOVED], mirror.faults_seen[FAULT_RUNAWAY],
                 mirror.faults_seen[FAULT_LEAK]);
        if (mirror.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
